FILE: design/double_ended_queue_with_search_core_defines.svh
// Assertion macros used by the deque sequencer.
`ifndef DOUBLE_ENDED_QUEUE_WITH_SEARCH_CORE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_WITH_SEARCH_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Condition that must hold on every clock edge out of reset.
`define DEQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Condition that, when true, implies another in the next cycle.
`define DEQ_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define DEQ_ASSERT(lbl, prop, msg)
`define DEQ_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

FILE: design/deq_pkg.sv
// Package: deque sizing constants, request and status codes, shared types.
package deq_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;

	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
	localparam logic [CNT_W:0] SUM_DEPTH = (CNT_W + 1)'(DEPTH);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

	localparam logic signed [DATA_W-1:0] EMPTY_MARK = -32'sd9999;

	typedef enum logic [2:0] {
		REQ_PUSH_REAR  = 3'd0,
		REQ_PUSH_FRONT = 3'd1,
		REQ_POP_REAR   = 3'd2,
		REQ_POP_FRONT  = 3'd3,
		REQ_SEARCH     = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_SEARCH,
		S_DONE
	} seq_state_t;

	// Ring store access from the sequencer.
	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [IDX_W-1:0]  raddr;
	} ram_req_t;

	// Finished transaction handed to the output register.
	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] value;
		logic [1:0]        status;
		logic              found;
	} seq_rsp_t;

	// Ring position base + off, off in 0..DEPTH, base below DEPTH.
	function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
		input logic [CNT_W-1:0] off);
		logic [CNT_W:0] sum;
		sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
		if (sum >= SUM_DEPTH) begin
			sum = sum - SUM_DEPTH;
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage

FILE: design/deq_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: design/deq_seq.sv
// Sequencer: request decode, head/count pointers and the shared search compare.
`include "double_ended_queue_with_search_core_defines.svh"

module deq_seq
	import deq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	input  logic [2:0]               req_type,
	input  logic signed [DATA_W-1:0] value,
	output logic                     busy,
	output ram_req_t                 ram_req,
	input  logic [DATA_W-1:0]        ram_rdata,
	input  logic                     rsp_free,
	output seq_rsp_t                 rsp
);

	seq_state_t state_q, state_d;

	logic [2:0]        req_q;
	logic [DATA_W-1:0] key_q;
	logic [IDX_W-1:0]  head_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  addr_q;
	logic [CNT_W-1:0]  remain_q;
	logic              cmp_v_q;
	logic              hit_q;
	logic [DATA_W-1:0] res_value_q;
	logic [1:0]        res_status_q;

	logic             is_full;
	logic             is_empty;
	logic             is_push;
	logic [IDX_W-1:0] head_dec;
	logic             match;

	assign is_full  = (count_q == CNT_FULL);
	assign is_empty = (count_q == '0);
	assign is_push  = req_q inside {REQ_PUSH_REAR, REQ_PUSH_FRONT};
	assign head_dec = (head_q == '0) ? IDX_LAST : head_q - IDX_W'(1);
	assign match    = cmp_v_q && (ram_rdata == key_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		ram_req       = '0;
		ram_req.wdata = key_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_DONE;
				case (req_q)
					REQ_PUSH_REAR: begin
						ram_req.we    = !is_full;
						ram_req.waddr = ring_pos(head_q, count_q);
					end
					REQ_PUSH_FRONT: begin
						ram_req.we    = !is_full;
						ram_req.waddr = head_dec;
					end
					REQ_POP_REAR: begin
						ram_req.re    = !is_empty;
						ram_req.raddr = ring_pos(head_q, count_q - CNT_W'(1));
						if (!is_empty) begin
							state_d = S_READ;
						end
					end
					REQ_POP_FRONT: begin
						ram_req.re    = !is_empty;
						ram_req.raddr = head_q;
						if (!is_empty) begin
							state_d = S_READ;
						end
					end
					REQ_SEARCH: begin
						state_d = S_SEARCH;
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_READ: begin
				state_d = S_DONE;
			end
			S_SEARCH: begin
				ram_req.re    = (remain_q != '0);
				ram_req.raddr = addr_q;
				if (remain_q == '0) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (rsp_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Pointers are control state; results are payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (state_q == S_EXEC) begin
			case (req_q)
				REQ_PUSH_REAR: begin
					if (!is_full) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				REQ_PUSH_FRONT: begin
					if (!is_full) begin
						head_q  <= head_dec;
						count_q <= count_q + CNT_W'(1);
					end
				end
				REQ_POP_REAR: begin
					if (!is_empty) begin
						count_q <= count_q - CNT_W'(1);
					end
				end
				REQ_POP_FRONT: begin
					if (!is_empty) begin
						head_q  <= ring_pos(head_q, CNT_W'(1));
						count_q <= count_q - CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				req_q        <= req_type;
				key_q        <= value;
				res_value_q  <= '0;
				res_status_q <= ST_OK;
				hit_q        <= 1'b0;
				cmp_v_q      <= 1'b0;
			end
			S_EXEC: begin
				addr_q   <= head_q;
				remain_q <= count_q;
				cmp_v_q  <= 1'b0;
				if (is_push && is_full) begin
					res_status_q <= ST_FULL;
				end
				if ((req_q == REQ_POP_REAR || req_q == REQ_POP_FRONT) && is_empty) begin
					res_status_q <= ST_EMPTY;
					res_value_q  <= EMPTY_MARK;
				end
			end
			S_READ: begin
				res_value_q <= ram_rdata;
			end
			S_SEARCH: begin
				// Compare of the entry read last cycle overlaps the next read.
				hit_q   <= hit_q | match;
				cmp_v_q <= (remain_q != '0);
				if (remain_q != '0) begin
					addr_q   <= ring_pos(addr_q, CNT_W'(1));
					remain_q <= remain_q - CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign busy       = (state_q != S_IDLE);
	assign rsp.done   = (state_q == S_DONE);
	assign rsp.value  = res_value_q;
	assign rsp.status = res_status_q;
	assign rsp.found  = hit_q;

	`DEQ_ASSERT(a_count_bound, count_q <= CNT_FULL, "entry count above depth")
	`DEQ_ASSERT(a_head_bound, 32'(head_q) < DEPTH, "head index outside ring")
	`DEQ_ASSERT_NEXT(a_accept_exec, state_q == S_IDLE && req_valid, state_q == S_EXEC, "accept did not start execution")
	`DEQ_ASSERT_NEXT(a_done_hold, state_q == S_DONE && !rsp_free, state_q == S_DONE && $stable(res_value_q), "result lost while output busy")

endmodule

FILE: design/double_ended_queue_with_search_core.sv
// Top level of the double-ended queue with search: ring store, sequencer, output register.
//
// A bounded double-ended queue of DEPTH (16) signed 32-bit values held in a
// ring store. Each request transaction pushes at the rear or front, pops from
// the rear or front, or searches for a value, and yields exactly one response
// transaction. A pop from an empty queue answers -9999 with status empty; a
// push to a full queue is dropped and answered with status full; a search
// reports found when any held entry equals the value. Unknown request codes
// answer all zeros and leave the queue untouched. Requests are handled one at
// a time: req_stall is high from acceptance until the response is handed to
// the output register. A push executes and then hands over its response;
// a pop adds a registered RAM read before the hand-over; a search walks the
// held entries with the one shared compare unit through the single RAM read
// port, one entry per cycle, and makes the last compare before the hand-over.
// Output stalls delay the hand-over only while the output register is still
// holding an earlier response. The output register lets a new request be
// accepted while the previous response is still stalled. The ring store has
// no reset; only entries that have been written are ever read.
module double_ended_queue_with_search_core
	import deq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  logic [2:0]               req_type,
	input  logic signed [DATA_W-1:0] value,
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output logic signed [DATA_W-1:0] result_value,
	output logic [1:0]               status,
	output logic                     found
);

	ram_req_t          ram_req;
	logic [DATA_W-1:0] ram_rdata;
	seq_rsp_t          seq_rsp;
	logic              busy;
	logic              rsp_free;

	logic              rsp_valid_q;
	logic [DATA_W-1:0] rsp_value_q;
	logic [1:0]        rsp_status_q;
	logic              rsp_found_q;

	// Ring store.
	deq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ram_req.we),
		.waddr(ram_req.waddr),
		.wdata(ram_req.wdata),
		.re   (ram_req.re),
		.raddr(ram_req.raddr),
		.rdata(ram_rdata)
	);

	// Request sequencer with the shared search compare.
	deq_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_type (req_type),
		.value    (value),
		.busy     (busy),
		.ram_req  (ram_req),
		.ram_rdata(ram_rdata),
		.rsp_free (rsp_free),
		.rsp      (seq_rsp)
	);

	assign req_stall = busy;

	// Output register: free when empty or being drained this cycle.
	assign rsp_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (seq_rsp.done && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_rsp.done && rsp_free) begin
			rsp_value_q  <= seq_rsp.value;
			rsp_status_q <= seq_rsp.status;
			rsp_found_q  <= seq_rsp.found;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign result_value = rsp_value_q;
	assign status       = rsp_status_q;
	assign found        = rsp_found_q;

endmodule

FILE: bench/deque_mirror_pkg.sv
// Mirror of the deque contents and the checker for its response transactions.
package deque_mirror_pkg;
	import deq_pkg::*;

	typedef struct {
		logic signed [DATA_W-1:0] value;
		status_t                  status;
		logic                     found;
	} reply_t;

	class deque_mirror;
		logic signed [DATA_W-1:0] ring [DEPTH];
		int unsigned front = 0;
		int unsigned held = 0;
		reply_t replies_due [$];
		int unsigned failures = 0;
		int unsigned requests = 0;
		int unsigned empty_pops = 0;
		int unsigned full_pushes = 0;
		int unsigned search_hits = 0;

		// Apply one accepted request and queue the response it must produce.
		function void apply_request(logic [2:0] code, logic signed [DATA_W-1:0] val);
			reply_t r;
			r.value = '0;
			r.status = ST_OK;
			r.found = 1'b0;
			requests++;
			case (code)
				REQ_PUSH_REAR, REQ_PUSH_FRONT: begin
					if (held == DEPTH) begin
						r.status = ST_FULL;
						full_pushes++;
					end else if (code == REQ_PUSH_REAR) begin
						ring[(front + held) % DEPTH] = val;
						held++;
					end else begin
						front = (front + DEPTH - 1) % DEPTH;
						ring[front] = val;
						held++;
					end
				end
				REQ_POP_REAR, REQ_POP_FRONT: begin
					if (held == 0) begin
						r.value = EMPTY_MARK;
						r.status = ST_EMPTY;
						empty_pops++;
					end else if (code == REQ_POP_REAR) begin
						r.value = ring[(front + held - 1) % DEPTH];
						held--;
					end else begin
						r.value = ring[front];
						front = (front + 1) % DEPTH;
						held--;
					end
				end
				REQ_SEARCH: begin
					for (int unsigned i = 0; i < held; i++) begin
						if (ring[(front + i) % DEPTH] == val) r.found = 1'b1;
					end
					if (r.found) search_hits++;
				end
				default: ;
			endcase
			replies_due.push_back(r);
		endfunction

		// A value currently held, so that searches hit; random when empty.
		function logic signed [DATA_W-1:0] pick_held();
			if (held == 0) return $urandom();
			return ring[(front + $urandom_range(held - 1)) % DEPTH];
		endfunction

		function void check_reply(logic signed [DATA_W-1:0] v, logic [1:0] s, logic f);
			reply_t e;
			if (replies_due.size() == 0) begin
				$error("unexpected response: result_value %0d status %0d found %0d", v, s, f);
				failures++;
				return;
			end
			e = replies_due.pop_front();
			if (v !== e.value) begin
				$error("result_value: expected %0d, got %0d", e.value, v);
				failures++;
			end
			if (s !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, s);
				failures++;
			end
			if (f !== e.found) begin
				$error("found: expected %0d, got %0d", e.found, f);
				failures++;
			end
		endfunction
	endclass

endpackage

FILE: bench/tb.sv
// Top-level testbench for the double-ended queue with search.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import deq_pkg::*;
	import deque_mirror_pkg::*;

	// Request codes 5..7 are undefined; the block answers all zeros.
	localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned ITEMS_PER_PHASE = 260;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic [2:0] req_type = REQ_PUSH_REAR;
	logic signed [DATA_W-1:0] value = '0;
	logic rsp_stall = 1'b0;
	logic req_stall;
	logic rsp_valid;
	logic signed [DATA_W-1:0] result_value;
	logic [1:0] status;
	logic found;

	// Idle percentages of the current phase; hold_orders bumps ask for a long hold-off.
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_orders = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;

	deque_mirror mirror = new();

	double_ended_queue_with_search_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req_type     (req_type),
		.value        (value),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.result_value (result_value),
		.status       (status),
		.found        (found)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Receiver: random stall per cycle, or a counted hold-off when one is ordered.
	// The hold-off is what lets the output register and the sequencer both fill,
	// so req_stall stays up while the sender keeps offering.
	always @(negedge clk) begin
		if (hold_seen != hold_orders) begin
			hold_seen = hold_orders;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Response monitor: every accepted response is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			mirror.check_reply(result_value, status, found);
		end
	end

	// Drive one request transaction. Called and returning at a falling edge; valid is
	// left high so a back-to-back transaction needs no second assignment in one step.
	task automatic send_request(input logic [2:0] code, input logic signed [DATA_W-1:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req_type <= code;
		value <= val;
		do @(posedge clk); while (req_stall);
		mirror.apply_request(code, val);
		@(negedge clk);
	endtask

	function automatic logic signed [DATA_W-1:0] corner_value();
		case ($urandom_range(5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return '0;
			3: return -32'sd1;
			4: return EMPTY_MARK;
			default: return 32'sd1;
		endcase
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_value();
		int unsigned roll;
		roll = $urandom_range(9);
		if (roll == 0) return corner_value();
		// a few small values so that stray duplicates appear in the ring
		if (roll == 1) return $urandom_range(7);
		return $urandom();
	endfunction

	// A stretch leaning toward filling, draining or neither, so both full and
	// empty are reached often with random contents in between.
	task automatic random_stretch(input int unsigned len);
		int unsigned lean, roll, push_pct, pop_pct;
		logic [2:0] code;
		logic signed [DATA_W-1:0] v;
		lean = $urandom_range(2);
		push_pct = (lean == 0) ? 60 : (lean == 1) ? 15 : 35;
		pop_pct = (lean == 0) ? 15 : (lean == 1) ? 60 : 35;
		repeat (len) begin
			roll = $urandom_range(99);
			if (roll < push_pct) begin
				code = $urandom_range(1) ? REQ_PUSH_FRONT : REQ_PUSH_REAR;
			end else if (roll < push_pct + pop_pct) begin
				code = $urandom_range(1) ? REQ_POP_FRONT : REQ_POP_REAR;
			end else if (roll < 95) begin
				code = REQ_SEARCH;
			end else begin
				code = REQ_UNUSED_FIRST + 3'($urandom_range(2));
			end
			if (code == REQ_SEARCH && $urandom_range(99) < 60) v = mirror.pick_held();
			else v = pick_value();
			send_request(code, v);
		end
	endtask

	// Fill past full and drain past empty while the receiver holds off.
	task automatic fill_under_hold();
		hold_orders++;
		for (int unsigned i = 0; i < DEPTH + 2; i++) begin
			send_request(i[0] ? REQ_PUSH_FRONT : REQ_PUSH_REAR, $urandom());
		end
		send_request(REQ_SEARCH, mirror.pick_held());
		for (int unsigned i = 0; i < DEPTH + 2; i++) begin
			send_request(i[0] ? REQ_POP_FRONT : REQ_POP_REAR, $urandom());
		end
	endtask

	initial begin
		int unsigned idle_plan [4];
		int unsigned stall_plan [4];
		int unsigned phase_start;
		idle_plan = '{0, 50, 0, 11};
		stall_plan = '{0, 0, 50, 11};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty pops and search, extreme values at both ends,
		// the empty marker stored as real data, last-entry search, unused codes.
		send_request(REQ_POP_REAR, 32'sh7fffffff);
		send_request(REQ_POP_FRONT, 32'sh80000000);
		send_request(REQ_SEARCH, '0);
		send_request(REQ_PUSH_REAR, 32'sh7fffffff);
		send_request(REQ_PUSH_FRONT, 32'sh80000000);
		send_request(REQ_PUSH_REAR, -32'sd1);
		send_request(REQ_PUSH_FRONT, EMPTY_MARK);
		send_request(REQ_PUSH_REAR, '0);
		send_request(REQ_SEARCH, 32'sh7fffffff);
		send_request(REQ_SEARCH, '0);
		send_request(REQ_SEARCH, 32'sd12345);
		send_request(REQ_UNUSED_FIRST, $urandom());
		send_request(REQ_UNUSED_FIRST + 3'd1, $urandom());
		send_request(REQ_UNUSED_FIRST + 3'd2, $urandom());
		send_request(REQ_POP_FRONT, $urandom());
		send_request(REQ_POP_REAR, $urandom());
		send_request(REQ_POP_REAR, $urandom());
		send_request(REQ_POP_FRONT, $urandom());
		send_request(REQ_POP_FRONT, $urandom());
		send_request(REQ_POP_FRONT, $urandom());

		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_plan[p];
			recv_stall_pct = stall_plan[p];
			if (p == 0) fill_under_hold();
			phase_start = mirror.requests;
			while (mirror.requests - phase_start < ITEMS_PER_PHASE) begin
				random_stretch($urandom_range(8, 40));
			end
		end
		req_valid <= 1'b0;

		while (mirror.replies_due.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mirror.replies_due.size() != 0) begin
			$error("%0d responses never arrived", mirror.replies_due.size());
			mirror.failures++;
		end

		$display("ran %0d request transactions under four idle/stall mixes and a long hold-off",
			mirror.requests);
		$display("empty pops %0d, dropped full pushes %0d, search hits %0d",
			mirror.empty_pops, mirror.full_pushes, mirror.search_hits);
		if (mirror.failures == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

endmodule
